>>> design/tbp_pkg.sv
// tbp_pkg: shared types, codes and constants for the transaction byte parser.
// Holds the field and status codes, the result beat struct and the field
// length table. Depends on nothing.
package tbp_pkg;

  // Field codes; parse phases use the same encoding (0..12).
  typedef enum logic [3:0] {
    FC_VER     = 4'd0,
    FC_TYPE    = 4'd1,
    FC_INCNT   = 4'd2,
    FC_TXID    = 4'd3,
    FC_IDX     = 4'd4,
    FC_SIG     = 4'd5,
    FC_KEY     = 4'd6,
    FC_OUTCNT  = 4'd7,
    FC_AMT     = 4'd8,
    FC_OTYPE   = 4'd9,
    FC_HASH    = 4'd10,
    FC_PLEN    = 4'd11,
    FC_PAYLOAD = 4'd12,
    FC_DISCARD = 4'd13
  } field_code_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_TRUNC    = 3'd1,
    ST_NONCANON = 3'd2,
    ST_ZERO_IN  = 3'd3,
    ST_MANY_IN  = 3'd4,
    ST_ZERO_OUT = 3'd5,
    ST_MANY_OUT = 3'd6,
    ST_TRAILING = 3'd7
  } status_t;

  // Upper bound on records per transaction, applied on top of the registers.
  localparam int MAX_ITEMS = 256;

  localparam int CountW    = 9;
  localparam int CfgIndexW = 2;
  localparam int CfgDataW  = 9;

  localparam logic [CfgIndexW-1:0] CFG_MODE    = 2'd0;
  localparam logic [CfgIndexW-1:0] CFG_MAX_IN  = 2'd1;
  localparam logic [CfgIndexW-1:0] CFG_MAX_OUT = 2'd2;

  // CompactSize prefixes for 16- and 32-bit counts (0xFF means 64-bit).
  localparam logic [7:0] CS_PREFIX16 = 8'hFD;
  localparam logic [7:0] CS_PREFIX32 = 8'hFE;

  typedef struct packed {
    logic              back_to_back;
    logic [CountW-1:0] max_in;
    logic [CountW-1:0] max_out;
  } cfg_t;

  typedef struct packed {
    logic [7:0]  byte_echo;
    field_code_t field_code;
    logic [7:0]  item_index;
    logic [7:0]  byte_offset;
    logic [63:0] field_value;
    logic        value_valid;
    logic        tx_done;
    status_t     status;
  } result_t;

  // Byte length of each fixed-size field; counts and payload are 0.
  function automatic logic [6:0] fixed_len(field_code_t f);
    logic [6:0] len;
    case (f)
      FC_VER:   len = 7'd4;
      FC_TYPE:  len = 7'd1;
      FC_TXID:  len = 7'd32;
      FC_IDX:   len = 7'd4;
      FC_SIG:   len = 7'd64;
      FC_KEY:   len = 7'd33;
      FC_AMT:   len = 7'd8;
      FC_OTYPE: len = 7'd1;
      FC_HASH:  len = 7'd20;
      FC_PLEN:  len = 7'd1;
      default:  len = 7'd0;
    endcase
    return len;
  endfunction

  // Effective count limit: min(register, MAX_ITEMS).
  function automatic logic [CountW-1:0] limit_of(logic [CountW-1:0] r);
    logic [CountW-1:0] lim;
    if (32'(r) > 32'(MAX_ITEMS)) lim = CountW'(MAX_ITEMS);
    else lim = r;
    return lim;
  endfunction

endpackage

>>> design/tbp_core.sv
// tbp_core: per-byte parse step and the parse state registers.
// One accepted byte updates the state and yields one result beat.
// Depends on tbp_pkg.
module tbp_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             accept,
  input  logic [7:0]       data_byte,
  input  logic             end_of_buffer,
  input  tbp_pkg::cfg_t    cfg,
  output tbp_pkg::result_t result
);

  tbp_pkg::field_code_t phase, phase_next;
  logic [7:0]  fbc, fbc_next;
  logic [63:0] acc, acc_next;
  logic [7:0]  prefix, prefix_next;
  logic [8:0]  items, items_next;
  logic [7:0]  rec, rec_next;
  logic [7:0]  pay, pay_next;
  logic        discarding, disc_next;
  logic        tx_complete, txc_next;

  always_comb begin
    tbp_pkg::field_code_t ph;
    tbp_pkg::field_code_t code;
    tbp_pkg::status_t     st;
    logic [7:0]  item, off, k, pay_dec;
    logic [63:0] val;
    logic        vv, done, fin, rec_end, noncanon, is_int, is_in;
    logic [3:0]  need;
    logic [8:0]  items_dec, lim;
    logic [7:0]  rec_inc;

    phase_next  = phase;
    fbc_next    = fbc;
    acc_next    = acc;
    prefix_next = prefix;
    items_next  = items;
    rec_next    = rec;
    pay_next    = pay;
    disc_next   = discarding;
    txc_next    = tx_complete;

    ph       = (phase > tbp_pkg::FC_PAYLOAD) ? tbp_pkg::FC_VER : phase;
    code     = tbp_pkg::FC_DISCARD;
    st       = tbp_pkg::ST_OK;
    item     = 8'd0;
    off      = 8'd0;
    val      = 64'd0;
    vv       = 1'b0;
    done     = 1'b0;
    fin      = 1'b0;
    rec_end  = 1'b0;
    noncanon = 1'b0;
    need     = 4'd8;
    k        = fbc - 8'd1;
    pay_dec  = (pay != 8'd0) ? pay - 8'd1 : 8'd0;
    items_dec = (items != 9'd0) ? items - 9'd1 : 9'd0;
    rec_inc  = rec + 8'd1;
    is_in    = (ph == tbp_pkg::FC_INCNT);
    lim      = tbp_pkg::limit_of(is_in ? cfg.max_in : cfg.max_out);
    is_int   = (ph == tbp_pkg::FC_VER) || (ph == tbp_pkg::FC_TYPE) ||
               (ph == tbp_pkg::FC_IDX) || (ph == tbp_pkg::FC_AMT) ||
               (ph == tbp_pkg::FC_OTYPE) || (ph == tbp_pkg::FC_PLEN);

    if (discarding) begin
      // silent discard until end of buffer
    end else if (tx_complete) begin
      st = tbp_pkg::ST_TRAILING;
    end else begin
      code = ph;
      off  = fbc;
      if (ph inside {[tbp_pkg::FC_TXID:tbp_pkg::FC_KEY],
                     [tbp_pkg::FC_AMT:tbp_pkg::FC_PAYLOAD]}) begin
        item = rec;
      end

      unique case (ph)
        tbp_pkg::FC_INCNT, tbp_pkg::FC_OUTCNT: begin
          if (fbc == 8'd0) begin
            prefix_next = data_byte;
            acc_next    = 64'd0;
            if (data_byte < tbp_pkg::CS_PREFIX16) begin
              fin = 1'b1;
              val = {56'd0, data_byte};
            end
          end else begin
            if (prefix == tbp_pkg::CS_PREFIX16) need = 4'd2;
            else if (prefix == tbp_pkg::CS_PREFIX32) need = 4'd4;
            else need = 4'd8;
            if (k < 8'd8) begin
              for (int i = 0; i < 8; i++) begin
                if (k[2:0] == 3'(i)) acc_next[8*i +: 8] = acc[8*i +: 8] | data_byte;
              end
            end
            if (fbc >= {4'd0, need}) begin
              fin = 1'b1;
              val = acc_next;
              if (need == 4'd2) noncanon = (val < 64'hFD);
              else if (need == 4'd4) noncanon = (val <= 64'hFFFF);
              else noncanon = (val <= 64'hFFFF_FFFF);
            end
          end
          if (fin) begin
            vv = 1'b1;
            if (noncanon) st = tbp_pkg::ST_NONCANON;
            else if (val == 64'd0) st = is_in ? tbp_pkg::ST_ZERO_IN : tbp_pkg::ST_ZERO_OUT;
            else if (val > {55'd0, lim}) st = is_in ? tbp_pkg::ST_MANY_IN : tbp_pkg::ST_MANY_OUT;
            else begin
              items_next = val[8:0];
              rec_next   = 8'd0;
              phase_next = is_in ? tbp_pkg::FC_TXID : tbp_pkg::FC_AMT;
            end
          end
        end
        tbp_pkg::FC_PAYLOAD: begin
          pay_next = pay_dec;
          if (pay_dec == 8'd0) begin
            fin     = 1'b1;
            rec_end = 1'b1;
          end
        end
        default: begin
          if (fbc == 8'd0) acc_next = 64'd0;
          if (is_int && fbc < 8'd8) begin
            for (int i = 0; i < 8; i++) begin
              if (fbc[2:0] == 3'(i)) acc_next[8*i +: 8] = acc_next[8*i +: 8] | data_byte;
            end
          end
          if ({1'b0, fbc} + 9'd1 >= {2'd0, tbp_pkg::fixed_len(ph)}) begin
            fin = 1'b1;
            if (is_int) begin
              vv  = 1'b1;
              val = acc_next;
            end
            case (ph)
              tbp_pkg::FC_VER:   phase_next = tbp_pkg::FC_TYPE;
              tbp_pkg::FC_TYPE:  phase_next = tbp_pkg::FC_INCNT;
              tbp_pkg::FC_TXID:  phase_next = tbp_pkg::FC_IDX;
              tbp_pkg::FC_IDX:   phase_next = tbp_pkg::FC_SIG;
              tbp_pkg::FC_SIG:   phase_next = tbp_pkg::FC_KEY;
              tbp_pkg::FC_KEY: begin
                items_next = items_dec;
                if (items_dec == 9'd0) begin
                  rec_next   = 8'd0;
                  phase_next = tbp_pkg::FC_OUTCNT;
                end else begin
                  rec_next   = rec_inc;
                  phase_next = tbp_pkg::FC_TXID;
                end
              end
              tbp_pkg::FC_AMT:   phase_next = tbp_pkg::FC_OTYPE;
              tbp_pkg::FC_OTYPE: phase_next = tbp_pkg::FC_HASH;
              tbp_pkg::FC_HASH:  phase_next = tbp_pkg::FC_PLEN;
              default: begin
                if (data_byte != 8'd0) begin
                  pay_next   = data_byte;
                  phase_next = tbp_pkg::FC_PAYLOAD;
                end else begin
                  rec_end = 1'b1;
                end
              end
            endcase
          end
        end
      endcase

      // end of an output record
      if (rec_end) begin
        items_next = items_dec;
        if (items_dec == 9'd0) begin
          done       = 1'b1;
          rec_next   = 8'd0;
          phase_next = tbp_pkg::FC_VER;
          if (!cfg.back_to_back) txc_next = 1'b1;
        end else begin
          rec_next   = rec_inc;
          phase_next = tbp_pkg::FC_AMT;
        end
      end

      fbc_next = fin ? 8'd0 : fbc + 8'd1;
      if (st == tbp_pkg::ST_OK && end_of_buffer && !done) st = tbp_pkg::ST_TRUNC;
    end

    // any error starts a discard run; end of buffer always restarts parsing
    if ((st != tbp_pkg::ST_OK && !discarding) || end_of_buffer) begin
      phase_next  = tbp_pkg::FC_VER;
      fbc_next    = 8'd0;
      acc_next    = 64'd0;
      prefix_next = 8'd0;
      items_next  = 9'd0;
      rec_next    = 8'd0;
      pay_next    = 8'd0;
      txc_next    = 1'b0;
      disc_next   = !end_of_buffer;
    end

    result.byte_echo   = data_byte;
    result.field_code  = code;
    result.item_index  = item;
    result.byte_offset = off;
    result.field_value = val;
    result.value_valid = vv;
    result.tx_done     = done;
    result.status      = st;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= tbp_pkg::FC_VER;
      fbc         <= 8'd0;
      acc         <= 64'd0;
      prefix      <= 8'd0;
      items       <= 9'd0;
      rec         <= 8'd0;
      pay         <= 8'd0;
      discarding  <= 1'b0;
      tx_complete <= 1'b0;
    end else if (accept) begin
      phase       <= phase_next;
      fbc         <= fbc_next;
      acc         <= acc_next;
      prefix      <= prefix_next;
      items       <= items_next;
      rec         <= rec_next;
      pay         <= pay_next;
      discarding  <= disc_next;
      tx_complete <= txc_next;
    end
  end

  a_disc_clean: assert property (@(posedge clk) disable iff (rst)
    discarding |-> (phase == tbp_pkg::FC_VER && fbc == 8'd0 && !tx_complete))
    else $error("discard run with live parse state");

  a_eob_restart: assert property (@(posedge clk) disable iff (rst)
    accept && end_of_buffer |=> (phase == tbp_pkg::FC_VER && !discarding && !tx_complete))
    else $error("parser not restarted after end of buffer");

  a_done_zero_items: assert property (@(posedge clk) disable iff (rst)
    accept && result.tx_done |=> (items == 9'd0 && rec == 8'd0))
    else $error("transaction done with records left");

endmodule

>>> design/tbp_outbuf.sv
// tbp_outbuf: two-deep result buffer (output register plus skid register).
// Lets the parser take a byte while a result beat waits on a stalled receiver.
// Depends on tbp_pkg.
module tbp_outbuf (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  tbp_pkg::result_t push_data,
  output logic             full,
  output logic             out_valid,
  input  logic             out_stall,
  output tbp_pkg::result_t out_data
);

  tbp_pkg::result_t skid;
  logic             pop;

  assign pop = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      full      <= 1'b0;
    end else begin
      if (push) begin
        if (!out_valid || pop) begin
          out_data  <= push_data;
          out_valid <= 1'b1;
        end else begin
          skid <= push_data;
          full <= 1'b1;
        end
      end else if (pop) begin
        if (full) begin
          out_data <= skid;
          full     <= 1'b0;
        end else begin
          out_valid <= 1'b0;
        end
      end
    end
  end

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    full |-> out_valid)
    else $error("skid holds a beat while output is empty");

  a_skid_drain: assert property (@(posedge clk) disable iff (rst)
    full && !out_stall |=> out_valid && !full)
    else $error("skid beat not moved to output");

endmodule

>>> design/transaction_byte_parser.sv
// transaction_byte_parser: top level of the byte-serial transaction parser.
// Holds the configuration registers and joins tbp_core and tbp_outbuf.
// Depends on tbp_pkg, tbp_core, tbp_outbuf.
//
// Usage:
//   Input channel: one buffer byte per beat (data_byte, end_of_buffer),
//   taken when in_valid is high and in_stall is low.
//   Output channel: one result beat per input beat, in order, tagging the
//   byte with its field, record index, offset, completed value, tx_done and
//   status; taken when out_valid is high and out_stall is low.
//   Each result beat is registered: in the output register, or in the skid
//   register while the output holds a beat. Throughput is one byte per cycle
//   while in_stall is low, set by the tbp_core step that updates the parse state.
//   When the receiver stalls, one more byte is taken into a skid register;
//   in_stall then rises until the receiver drains a beat.
//   Configuration: cfg_write/cfg_index/cfg_data write back_to_back_mode,
//   max_input_count or max_output_count; write only while idle.
//   Reset clears the parse state and the buffer and restores the register
//   defaults (strict mode, both limits 256). There is no clearing pass.
module transaction_byte_parser (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [tbp_pkg::CfgIndexW-1:0]  cfg_index,
  input  logic [tbp_pkg::CfgDataW-1:0]   cfg_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [7:0]                     data_byte,
  input  logic                           end_of_buffer,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [7:0]                     byte_echo,
  output logic [3:0]                     field_code,
  output logic [7:0]                     item_index,
  output logic [7:0]                     byte_offset,
  output logic [63:0]                    field_value,
  output logic                           value_valid,
  output logic                           tx_done,
  output logic [2:0]                     status
);

  tbp_pkg::cfg_t    cfg;
  tbp_pkg::result_t step_result;
  tbp_pkg::result_t out_data;
  logic             accept;
  logic             buf_full;

  // register file; indexes past the last register are ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.back_to_back <= 1'b0;
      cfg.max_in       <= tbp_pkg::CountW'(tbp_pkg::MAX_ITEMS);
      cfg.max_out      <= tbp_pkg::CountW'(tbp_pkg::MAX_ITEMS);
    end else if (cfg_write) begin
      unique case (cfg_index)
        tbp_pkg::CFG_MODE:    cfg.back_to_back <= cfg_data[0];
        tbp_pkg::CFG_MAX_IN:  cfg.max_in       <= cfg_data;
        tbp_pkg::CFG_MAX_OUT: cfg.max_out      <= cfg_data;
        default: ;
      endcase
    end
  end

  // stall only when both the output and skid registers hold beats
  assign in_stall = buf_full;
  assign accept   = in_valid && !in_stall;

  tbp_core u_core (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .data_byte     (data_byte),
    .end_of_buffer (end_of_buffer),
    .cfg           (cfg),
    .result        (step_result)
  );

  tbp_outbuf u_outbuf (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .push_data (step_result),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  assign byte_echo   = out_data.byte_echo;
  assign field_code  = out_data.field_code;
  assign item_index  = out_data.item_index;
  assign byte_offset = out_data.byte_offset;
  assign field_value = out_data.field_value;
  assign value_valid = out_data.value_valid;
  assign tx_done     = out_data.tx_done;
  assign status      = out_data.status;

endmodule
